FILE: rtl/ofr_pkg.sv
// ----------------------------------------------------------------------------
// ofr_pkg
// Shared constants, types and the glyph table of the text framebuffer
// refresher.
// ----------------------------------------------------------------------------
package ofr_pkg;

    // Default geometry
    localparam int OFR_WIDTH       = 128;
    localparam int OFR_PAGES       = 8;
    localparam int OFR_CHUNK_BYTES = 16;

    // Character cell
    localparam int GLYPH_COLS = 5;
    localparam int CELL_COLS  = 6;

    // Bus bytes
    localparam logic [7:0] CTRL_CMD     = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW  = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] NIBBLE       = 8'h0F;

    // Register reset values
    localparam logic [6:0] I2C_ADDR_RESET   = 7'h3C;
    localparam logic [7:0] COL_OFFSET_RESET = 8'd2;

    // Register indexes
    localparam logic CFG_I2C_ADDRESS   = 1'b0;
    localparam logic CFG_COLUMN_OFFSET = 1'b1;

    // Request kinds
    localparam logic [1:0] REQ_DRAW    = 2'd0;
    localparam logic [1:0] REQ_CLEAR   = 2'd1;
    localparam logic [1:0] REQ_REFRESH = 2'd2;

    typedef struct packed {
        logic [6:0] i2c_address;
        logic [7:0] column_offset;
    } ofr_cfg_t;

    // Five glyph columns, leftmost column in the top byte; unknown codes are blank
    function automatic logic [39:0] glyph_bits(input logic [7:0] code);
        logic [39:0] g;
        g = '0;
        case (code) inside
            8'h3A:        g = 40'h00_36_36_00_00; // ':'
            8'h2E:        g = 40'h00_00_60_60_00; // '.'
            8'h61:        g = 40'h20_54_54_54_78; // 'a'
            8'h63:        g = 40'h38_44_44_44_20; // 'c'
            8'h64:        g = 40'h38_44_44_44_78; // 'd'
            8'h65:        g = 40'h38_54_54_54_18; // 'e'
            8'h66:        g = 40'h08_7E_09_01_02; // 'f'
            8'h67:        g = 40'h18_A4_A4_A4_7C; // 'g'
            8'h68:        g = 40'h7F_08_04_04_78; // 'h'
            8'h69:        g = 40'h00_44_7D_40_00; // 'i'
            8'h6C:        g = 40'h00_41_7F_40_00; // 'l'
            8'h6E:        g = 40'h7C_04_02_04_78; // 'n'
            8'h6F:        g = 40'h38_44_44_44_38; // 'o'
            8'h70:        g = 40'hFC_24_24_24_18; // 'p'
            8'h72:        g = 40'h7C_08_04_04_08; // 'r'
            8'h73:        g = 40'h48_54_54_54_24; // 's'
            8'h74:        g = 40'h04_3F_44_40_20; // 't'
            8'h77, 8'h57: g = 40'h7C_40_30_40_7C; // 'w', 'W'
            8'h43:        g = 40'h3E_41_41_41_22; // 'C'
            8'h50:        g = 40'h7F_09_09_09_06; // 'P'
            8'h44:        g = 40'h7F_41_41_22_1C; // 'D'
            default:      g = '0;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/ofr_frame_ram.sv
// ----------------------------------------------------------------------------
// ofr_frame_ram
// Framebuffer store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ofr_frame_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ofr_refresh.sv
// ----------------------------------------------------------------------------
// ofr_refresh
// Page refresh sequencer: emits one bus write per start, one byte a cycle
// while the receiver takes them, through a read stage and an output register.
// ----------------------------------------------------------------------------
module ofr_refresh import ofr_pkg::*; #(
    parameter int WIDTH       = OFR_WIDTH,
    parameter int PAGES       = OFR_PAGES,
    parameter int CHUNK_BYTES = OFR_CHUNK_BYTES,
    parameter int DEPTH       = OFR_WIDTH * OFR_PAGES,
    parameter int ADDR_W      = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  ofr_cfg_t          cfg,
    output logic              busy,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,  // [7:0] tx_byte, [14:8] target_address, [15] zero
    output logic              m_tlast,  // last_of_transaction
    output logic              m_tuser   // last_of_frame
);

    localparam int COL_W  = $clog2(WIDTH);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int BI_MAX = (CHUNK_BYTES > 2) ? CHUNK_BYTES : 2;
    localparam int BI_W   = $clog2(BI_MAX + 1);

    typedef enum logic [2:0] {
        K_PAGE = 3'b001,
        K_COL  = 3'b010,
        K_DATA = 3'b100
    } ofr_kind_t;

    ofr_kind_t         kind_reg;
    logic              busy_reg;
    logic [BI_W-1:0]   bi_reg;
    logic [COL_W-1:0]  col_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [ADDR_W-1:0] rd_addr_reg;

    logic              p_valid_reg;
    logic              p_is_data_reg;
    logic [7:0]        p_byte_reg;
    logic [6:0]        p_addr_reg;
    logic              p_lt_reg;
    logic              p_lf_reg;

    logic              m_tvalid_reg;
    logic [7:0]        o_byte_reg;
    logic [6:0]        o_addr_reg;
    logic              o_lt_reg;
    logic              o_lf_reg;

    logic              o_free;
    logic              p_move;
    logic              p_free;
    logic              issue;
    logic [7:0]        gen_byte;
    logic              gen_is_data;
    logic              gen_last;
    logic              gen_lf;
    logic              col_end;
    logic              page_end;

    assign o_free   = !m_tvalid_reg || m_tready;
    assign p_move   = p_valid_reg && o_free;
    assign p_free   = !p_valid_reg || p_move;
    assign issue    = busy_reg && p_free;
    assign col_end  = (col_reg == COL_W'(WIDTH - 1));
    assign page_end = (page_reg == PAGE_W'(PAGES - 1));

    always_comb begin
        gen_byte    = CTRL_CMD;
        gen_is_data = 1'b0;
        gen_last    = 1'b0;
        gen_lf      = 1'b0;
        unique case (kind_reg)
            K_PAGE: begin
                if (bi_reg != '0) begin
                    gen_byte = CMD_PAGE | 8'(page_reg);
                    gen_last = 1'b1;
                end
            end
            K_COL: begin
                if (bi_reg == BI_W'(1)) begin
                    gen_byte = CMD_COL_LOW | (cfg.column_offset & NIBBLE);
                end else if (bi_reg != '0) begin
                    gen_byte = CMD_COL_HIGH | ((cfg.column_offset >> 4) & NIBBLE);
                    gen_last = 1'b1;
                end
            end
            K_DATA: begin
                if (bi_reg == '0) begin
                    gen_byte = CTRL_DATA;
                end else begin
                    gen_is_data = 1'b1;
                    gen_last    = (bi_reg == BI_W'(CHUNK_BYTES)) || col_end;
                    gen_lf      = col_end && page_end;
                end
            end
            default: begin
                gen_byte = CTRL_CMD;
            end
        endcase
    end

    // Sequencer position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= K_PAGE;
            busy_reg    <= 1'b0;
            bi_reg      <= '0;
            col_reg     <= '0;
            page_reg    <= '0;
            rd_addr_reg <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
            end
            if (issue) begin
                if (gen_last) begin
                    bi_reg   <= '0;
                    busy_reg <= 1'b0;
                    unique case (kind_reg)
                        K_PAGE:  kind_reg <= K_COL;
                        K_COL:   kind_reg <= K_DATA;
                        K_DATA:  kind_reg <= col_end ? K_PAGE : K_DATA;
                        default: kind_reg <= K_PAGE;
                    endcase
                end else begin
                    bi_reg <= bi_reg + BI_W'(1);
                end
                if (gen_is_data) begin
                    col_reg     <= col_end ? '0 : col_reg + COL_W'(1);
                    rd_addr_reg <= (rd_addr_reg == ADDR_W'(DEPTH - 1)) ? '0
                                 : rd_addr_reg + ADDR_W'(1);
                    if (col_end) begin
                        page_reg <= page_end ? '0 : page_reg + PAGE_W'(1);
                    end
                end
            end
        end
    end

    // Read stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (p_free) begin
                p_valid_reg <= issue;
            end
            if (o_free) begin
                m_tvalid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            p_is_data_reg <= gen_is_data;
            p_byte_reg    <= gen_byte;
            p_addr_reg    <= cfg.i2c_address;
            p_lt_reg      <= gen_last;
            p_lf_reg      <= gen_lf;
        end
        if (p_move) begin
            o_byte_reg <= p_is_data_reg ? rd_data : p_byte_reg;
            o_addr_reg <= p_addr_reg;
            o_lt_reg   <= p_lt_reg;
            o_lf_reg   <= p_lf_reg;
        end
    end

    assign busy     = busy_reg;
    assign rd_en    = issue && gen_is_data;
    assign rd_addr  = rd_addr_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, o_addr_reg, o_byte_reg};
    assign m_tlast  = o_lt_reg;
    assign m_tuser  = o_lf_reg;

    // Read address tracks page and column
    a_addr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_addr_reg == ADDR_W'(int'(page_reg) * WIDTH + int'(col_reg)))
        else $error("refresh read address out of step with page and column");

    // A stalled read stage must keep its memory data
    a_hold_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && !o_free) |-> !rd_en)
        else $error("memory read issued while read stage stalled");

    // Page commands always start at column zero
    a_page_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg == K_PAGE) |-> (col_reg == '0))
        else $error("page command pending mid-page");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && o_lf_reg) |-> o_lt_reg)
        else $error("frame end not on final byte of a write");

endmodule

FILE: rtl/oled_text_framebuffer_refresher_unit.sv
// ----------------------------------------------------------------------------
// oled_text_framebuffer_refresher_unit
// Text framebuffer with a 5x8 font and a paged refresh stream for a
// monochrome display controller on a two-wire bus.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (s_*) carry a request: draw one character, clear the
//   framebuffer, or emit the next bus write of the refresh stream. Output
//   transactions (m_*) carry one payload byte each, with the bus address,
//   tlast on the final byte of a write and tuser on the final byte of the
//   whole frame.
//   Requests are taken one at a time. A draw writes its character cell after
//   acceptance, one framebuffer column per cycle. A clear sweeps all
//   WIDTH*PAGES bytes of the store (1024 by default). A refresh issues one
//   byte per cycle while the receiver takes them, data bytes from the store
//   read port; its first byte passes the busy register, the read stage and
//   the output register to m_tdata. Once the write's last byte is issued,
//   busy clears, the state register returns to idle and the next request can
//   be taken. After reset the store is swept to zero while s_tready stays low;
//   configuration writes are taken at any time. When the receiver stalls, the
//   output register and the read stage hold, and the sequencer waits.
// ----------------------------------------------------------------------------
module oled_text_framebuffer_refresher_unit import ofr_pkg::*; #(
    parameter int WIDTH       = OFR_WIDTH,
    parameter int PAGES       = OFR_PAGES,
    parameter int CHUNK_BYTES = OFR_CHUNK_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [15:8] start_x, [21:16] start_y, zero
    input  logic [2:0]  s_tuser,   // [1:0] req_type, [2] first_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [14:8] target_address, [15] zero
    output logic        m_tlast,   // last_of_transaction
    output logic        m_tuser,   // last_of_frame
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int DEPTH  = WIDTH * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic signed [8:0] WIDTH_S   = 9'(WIDTH);
    localparam logic signed [8:0] COL_LIMIT = 9'(WIDTH - CELL_COLS);
    localparam logic [2:0]        LAST_CELL = 3'(CELL_COLS - 1);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_CLEAR   = 4'b0010,
        ST_DRAW    = 4'b0100,
        ST_REFRESH = 4'b1000
    } ofr_state_t;

    ofr_state_t         state_reg;
    ofr_state_t         state_next;
    ofr_cfg_t           cfg_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic signed [8:0]  draw_col_reg;
    logic [PAGE_W-1:0]  draw_page_reg;
    logic               active_reg;
    logic [2:0]         cell_reg;
    logic [39:0]        glyph_reg;

    logic               accept;
    logic [1:0]         req;
    logic               first;
    logic signed [8:0]  x9;
    logic [5:0]         y;
    logic               bad_start;
    logic               eff_active;
    logic signed [8:0]  eff_col;
    logic               go_draw;
    logic signed [8:0]  col_w;
    logic               col_ok;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               rf_start;
    logic               rf_busy;
    logic               rf_rd_en;
    logic [ADDR_W-1:0]  rf_rd_addr;
    logic [7:0]         rf_rd_data;

    assign accept = s_tvalid && s_tready;
    assign req    = s_tuser[1:0];
    assign first  = s_tuser[2];
    assign x9     = $signed({s_tdata[15], s_tdata[15:8]});
    assign y      = s_tdata[21:16];

    // A new string is rejected off the right edge, off a page boundary or below
    assign bad_start  = (x9 >= WIDTH_S) || (y[2:0] != 3'd0)
                      || ({1'b0, y[5:3]} >= 4'(PAGES));
    assign eff_active = first ? !bad_start : active_reg;
    assign eff_col    = first ? x9 : draw_col_reg;
    assign go_draw    = eff_active && (eff_col < COL_LIMIT);

    assign col_w  = draw_col_reg + $signed({6'd0, cell_reg});
    assign col_ok = (col_w >= 9'sd0) && (col_w < WIDTH_S);

    always_comb begin
        state_next = state_reg;
        rf_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_DRAW:    state_next = go_draw ? ST_DRAW : ST_IDLE;
                        REQ_CLEAR:   state_next = ST_CLEAR;
                        REQ_REFRESH: begin
                            state_next = ST_REFRESH;
                            rf_start   = 1'b1;
                        end
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW: begin
                if (cell_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REFRESH: begin
                if (!rf_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            draw_col_reg  <= '0;
            draw_page_reg <= '0;
            active_reg    <= 1'b0;
            cell_reg      <= '0;
            cfg_reg       <= '{i2c_address: I2C_ADDR_RESET, column_offset: COL_OFFSET_RESET};
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_I2C_ADDRESS:   cfg_reg.i2c_address   <= cfg_data[6:0];
                    CFG_COLUMN_OFFSET: cfg_reg.column_offset <= cfg_data;
                    default:           cfg_reg <= cfg_reg;
                endcase
            end
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end else begin
                clr_addr_reg <= '0;
            end
            if (accept && (req == REQ_DRAW)) begin
                active_reg <= eff_active;
                if (first && !bad_start) begin
                    draw_col_reg  <= x9;
                    draw_page_reg <= PAGE_W'(y[5:3]);
                end
                cell_reg <= '0;
            end
            if (state_reg == ST_DRAW) begin
                if (cell_reg == LAST_CELL) begin
                    draw_col_reg <= draw_col_reg + 9'(CELL_COLS);
                end
                cell_reg <= cell_reg + 3'd1;
            end
        end
    end

    // Glyph columns shift out leftmost first; the spacer column is the shifted-in zero
    always_ff @(posedge aclk) begin
        if (accept && (req == REQ_DRAW)) begin
            glyph_reg <= glyph_bits(s_tdata[7:0]);
        end else if (state_reg == ST_DRAW) begin
            glyph_reg <= {glyph_reg[31:0], 8'h00};
        end
    end

    assign ram_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_DRAW) && col_ok);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg
                     : ADDR_W'(int'(draw_page_reg) * WIDTH + int'(col_w[7:0]));
    assign ram_wdata = (state_reg == ST_CLEAR) ? 8'h00 : glyph_reg[39:32];

    assign s_tready = (state_reg == ST_IDLE);

    ofr_frame_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (rf_rd_en),
        .rd_addr (rf_rd_addr),
        .rd_data (rf_rd_data)
    );

    ofr_refresh #(
        .WIDTH       (WIDTH),
        .PAGES       (PAGES),
        .CHUNK_BYTES (CHUNK_BYTES),
        .DEPTH       (DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_refresh (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rf_start),
        .cfg      (cfg_reg),
        .busy     (rf_busy),
        .rd_en    (rf_rd_en),
        .rd_addr  (rf_rd_addr),
        .rd_data  (rf_rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Drawing only ever starts left of the full-line limit
    a_draw_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW) |-> (draw_col_reg < COL_LIMIT))
        else $error("drawing past the full-line limit");

    // Store writes and refresh reads never share a cycle
    a_port_split: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rf_rd_en && ram_we))
        else $error("framebuffer write during refresh read");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !rf_busy)
        else $error("request taken while refresh still issuing");

endmodule
